>>> hw/rtl/pds_pkg.sv
package pds_pkg;

    // Search space
    localparam int POSTDIV_MAX_DEF = 7;
    localparam int PD_W            = 3;

    // Field widths
    localparam int TARGET_W = 11;
    localparam int CFG_W    = 11;
    localparam int FB_W     = 8;
    localparam int FB_OUT_W = 9;
    localparam int ERR_W    = 3;
    localparam int WANT_W   = 17;
    localparam int SEL_W    = 11;

    // PLL limits
    localparam int REF_MHZ    = 12;
    localparam int ROUND_HALF = 6;
    localparam int FB_MIN     = 16;
    localparam int FB_MAX     = 320;
    localparam int VCO_MIN    = 750;
    localparam int VCO_MAX    = 1600;

    // Feedback range that satisfies both the divider and the VCO limits
    localparam int FB_LO_VCO = (VCO_MIN + REF_MHZ - 1) / REF_MHZ;
    localparam int FB_HI_VCO = VCO_MAX / REF_MHZ;
    localparam int FB_LO     = (FB_LO_VCO > FB_MIN) ? FB_LO_VCO : FB_MIN;
    localparam int FB_HI     = (FB_HI_VCO < FB_MAX) ? FB_HI_VCO : FB_MAX;

    // Wanted VCO window that rounds into that feedback range
    localparam int WANT_MIN = FB_LO * REF_MHZ - ROUND_HALF;
    localparam int WANT_MAX = FB_HI * REF_MHZ + REF_MHZ - 1 - ROUND_HALF;

    // Divide by three through a reciprocal: floor(t * 683 / 2048) for t < 1024
    localparam int RECIP3    = 683;
    localparam int RECIP3_SH = 11;

    // Configuration reset values
    localparam int STOCK_CLOCK_RST = 150;

    typedef enum logic [0:0] {
        CFG_STOCK_CLOCK = 1'b0,
        CFG_OVERCLOCK   = 1'b1
    } t_cfg_idx;

    // One evaluated divider set
    typedef struct packed {
        logic             ok;
        logic [ERR_W-1:0] err;
        logic [FB_W-1:0]  fb;
        logic [PD_W-1:0]  p1;
        logic [PD_W-1:0]  p2;
    } t_cand;

endpackage

>>> hw/rtl/pds_cand.sv
module pds_cand
    import pds_pkg::*;
#(
    parameter int P1 = 1,
    parameter int P2 = 1
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [TARGET_W-1:0] i_target,
    input  logic                i_refused,
    output t_cand               o_cand
);

    localparam int MULT = P1 * P2;

    logic [WANT_W-1:0]    w_want;
    logic                 w_hit;
    logic                 r_hit;
    logic [SEL_W-1:0]     r_want;

    logic [SEL_W:0]       w_sum;
    logic [SEL_W-2:0]     w_quarter;
    logic [RECIP3_SH+FB_W-1:0] w_prod;
    logic [FB_W-1:0]      w_fb;
    logic [SEL_W-2:0]     w_three_q;
    logic [SEL_W-2:0]     w_rem3;
    logic [3:0]           w_rem12;
    logic [ERR_W-1:0]     w_err;
    t_cand                r_cand;

    // Stage 1: wanted VCO and window check
    assign w_want = WANT_W'(i_target) * WANT_W'(MULT);
    assign w_hit  = !i_refused
                  && (w_want >= WANT_W'(WANT_MIN))
                  && (w_want <= WANT_W'(WANT_MAX));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit  <= w_hit;
            r_want <= w_want[SEL_W-1:0];
        end
    end

    // Stage 2: round to nearest feedback divider, split (want + 6) / 12
    assign w_sum     = {1'b0, r_want} + (SEL_W+1)'(ROUND_HALF);
    assign w_quarter = w_sum[SEL_W:2];
    assign w_prod    = (RECIP3_SH+FB_W)'(w_quarter) * (RECIP3_SH+FB_W)'(RECIP3);
    assign w_fb      = w_prod[RECIP3_SH+FB_W-1:RECIP3_SH];
    assign w_three_q = (SEL_W-1)'(w_fb) + (SEL_W-1)'({w_fb, 1'b0});
    assign w_rem3    = w_quarter - w_three_q;
    assign w_rem12   = {w_rem3[1:0], w_sum[1:0]};

    // VCO minus want is 6 minus the remainder; take its magnitude
    assign w_err = (w_rem12 > 4'(ROUND_HALF)) ? ERR_W'(w_rem12 - 4'(ROUND_HALF))
                                              : ERR_W'(4'(ROUND_HALF) - w_rem12);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cand.ok  <= r_hit;
            r_cand.err <= w_err;
            r_cand.fb  <= w_fb;
            r_cand.p1  <= PD_W'(P1);
            r_cand.p2  <= PD_W'(P2);
        end
    end

    assign o_cand = r_cand;

endmodule

>>> hw/rtl/pds_min.sv
module pds_min
    import pds_pkg::*;
#(
    parameter int N = POSTDIV_MAX_DEF * POSTDIV_MAX_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_cand i_cand [N],
    output logic  o_vld,
    output t_cand o_cand
);

    localparam int L = (N > 1) ? $clog2(N) : 0;
    localparam int W = 1 << L;

    t_cand w_node [L+1][W];
    logic  w_vld  [L+1];
    t_cand r_out;
    logic  r_out_vld;

    // Take the right entry only when it is strictly better, so earlier wins ties
    function automatic t_cand pick(input t_cand a, input t_cand b);
        logic [ERR_W:0] ka;
        logic [ERR_W:0] kb;
        ka = {!a.ok, a.err};
        kb = {!b.ok, b.err};
        return (kb < ka) ? b : a;
    endfunction

    // Pad the leaves with empty entries
    generate
        for (genvar j = 0; j < W; j++) begin : g_leaf
            if (j < N) begin : g_real
                assign w_node[0][j] = i_cand[j];
            end else begin : g_pad
                assign w_node[0][j] = '0;
            end
        end
    endgenerate
    assign w_vld[0] = i_vld;

    // Compare pairs level by level; register after every second level
    generate
        for (genvar l = 0; l < L; l++) begin : g_lvl
            localparam int CNT = W >> (l + 1);
            if ((l % 2 == 1) && (l < L - 1)) begin : g_reg
                t_cand r_node [CNT];
                logic  r_vld;
                for (genvar j = 0; j < CNT; j++) begin : g_node
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_node[j] <= pick(w_node[l][2*j], w_node[l][2*j+1]);
                        end
                    end
                    assign w_node[l+1][j] = r_node[j];
                end
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_vld <= 1'b0;
                    end else if (i_en) begin
                        r_vld <= w_vld[l];
                    end
                end
                assign w_vld[l+1] = r_vld;
            end else begin : g_comb
                for (genvar j = 0; j < CNT; j++) begin : g_node
                    assign w_node[l+1][j] = pick(w_node[l][2*j], w_node[l][2*j+1]);
                end
                assign w_vld[l+1] = w_vld[l];
            end
            for (genvar j = CNT; j < W; j++) begin : g_idle
                assign w_node[l+1][j] = '0;
            end
        end
    endgenerate

    // Final result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= w_node[L][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= w_vld[L];
        end
    end

    assign o_vld  = r_out_vld;
    assign o_cand = r_out;

endmodule

>>> hw/rtl/pll_divider_search.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+--------------------------------------
// in        | input     | i_in_valid / o_in_ready    | i_target_mhz
// out       | output    | o_out_valid / i_out_ready  | o_found, o_ref_divider,
//           |           |                            | o_feedback_divider, o_post_divider_one,
//           |           |                            | o_post_divider_two, o_vco_error_mhz
// cfg       | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item enters per cycle while no result is held at the output. The pipeline is the input
// register, two stages per divider pair, then the compare tree at two levels per stage.
// Synchronous active-low reset clears the valid bits and the configuration.
// The whole pipeline holds while a result waits at the output; nothing is dropped or doubled.
module pll_divider_search
    import pds_pkg::*;
#(
    parameter int POSTDIV_MAX = POSTDIV_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [TARGET_W-1:0] i_target_mhz,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_found,
    output logic                o_ref_divider,
    output logic [FB_OUT_W-1:0] o_feedback_divider,
    output logic [PD_W-1:0]     o_post_divider_one,
    output logic [PD_W-1:0]     o_post_divider_two,
    output logic [ERR_W-1:0]    o_vco_error_mhz,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int N = POSTDIV_MAX * POSTDIV_MAX;

    logic [CFG_W-1:0]    r_stock_clock_mhz;
    logic                r_overclock_allowed;

    logic                w_en;
    logic                r_vld0;
    logic                r_vld1;
    logic                r_vld2;
    logic [TARGET_W-1:0] r_target;
    logic                r_refused;
    t_cand               w_cand [N];
    logic                w_out_vld;
    t_cand               w_best;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stock_clock_mhz   <= CFG_W'(STOCK_CLOCK_RST);
            r_overclock_allowed <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_STOCK_CLOCK: r_stock_clock_mhz   <= i_cfg_data;
                CFG_OVERCLOCK:   r_overclock_allowed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance everything unless a finished item is stuck at the output
    assign w_en       = !w_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    // Input stage: capture the target and the limit check
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_target  <= i_target_mhz;
            r_refused <= (i_target_mhz > r_stock_clock_mhz) && !r_overclock_allowed;
        end
    end

    // Valid bits for the input and candidate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (w_en) begin
            r_vld0 <= i_in_valid;
            r_vld1 <= r_vld0;
            r_vld2 <= r_vld1;
        end
    end

    // One evaluator per divider pair, second divider in the outer order
    generate
        for (genvar p2 = 1; p2 <= POSTDIV_MAX; p2++) begin : g_p2
            for (genvar p1 = 1; p1 <= POSTDIV_MAX; p1++) begin : g_p1
                pds_cand #(
                    .P1 (p1),
                    .P2 (p2)
                ) u_cand (
                    .i_clk     (i_clk),
                    .i_en      (w_en),
                    .i_target  (r_target),
                    .i_refused (r_refused),
                    .o_cand    (w_cand[(p2-1)*POSTDIV_MAX + (p1-1)])
                );
            end
        end
    endgenerate

    // Smallest error, earliest pair on a tie
    pds_min #(
        .N (N)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld2),
        .i_cand  (w_cand),
        .o_vld   (w_out_vld),
        .o_cand  (w_best)
    );

    // Zero every field when nothing fits
    assign o_out_valid        = w_out_vld;
    assign o_found            = w_best.ok;
    assign o_ref_divider      = w_best.ok;
    assign o_feedback_divider = w_best.ok ? FB_OUT_W'(w_best.fb) : '0;
    assign o_post_divider_one = w_best.ok ? w_best.p1 : '0;
    assign o_post_divider_two = w_best.ok ? w_best.p2 : '0;
    assign o_vco_error_mhz    = w_best.ok ? w_best.err : '0;

endmodule

>>> test/pds_result_checker.sv
module pds_result_checker
    import pds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [TARGET_W-1:0] i_target_mhz,

    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_found,
    input  logic                i_ref_divider,
    input  logic [FB_OUT_W-1:0] i_feedback_divider,
    input  logic [PD_W-1:0]     i_post_divider_one,
    input  logic [PD_W-1:0]     i_post_divider_two,
    input  logic [ERR_W-1:0]    i_vco_error_mhz,

    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  t_cfg_idx            i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,

    output int                  o_fail_count,
    output int                  o_pending
);

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                found;
        logic                ref_div;
        logic [FB_OUT_W-1:0] feedback;
        logic [PD_W-1:0]     pd_one;
        logic [PD_W-1:0]     pd_two;
        logic [ERR_W-1:0]    vco_err;
    } t_divider_set;

    t_divider_set      divider_sets_due[$];
    logic [CFG_W-1:0]  stock_limit;
    logic              overclock_en;
    int                mismatches = 0;
    int                results_seen = 0;

    // Search all post-divider pairs for the closest VCO; earliest pair wins a tie
    function automatic t_divider_set search_dividers(input logic [TARGET_W-1:0] target,
                                                     input logic [CFG_W-1:0] limit,
                                                     input logic oc_en);
        t_divider_set best;
        int want;
        int fb;
        int vco;
        int err;
        best = '0;
        best.target = target;
        if (!(target > limit && !oc_en)) begin
            for (int p2 = 1; p2 <= POSTDIV_MAX_DEF; p2++) begin
                for (int p1 = 1; p1 <= POSTDIV_MAX_DEF; p1++) begin
                    want = int'(target) * p1 * p2;
                    fb   = (want + ROUND_HALF) / REF_MHZ;
                    vco  = REF_MHZ * fb;
                    err  = (vco > want) ? vco - want : want - vco;
                    if (fb >= FB_MIN && fb <= FB_MAX && vco >= VCO_MIN && vco <= VCO_MAX &&
                        (!best.found || err < int'(best.vco_err))) begin
                        best.found    = 1'b1;
                        best.ref_div  = 1'b1;
                        best.feedback = FB_OUT_W'(fb);
                        best.pd_one   = PD_W'(p1);
                        best.pd_two   = PD_W'(p2);
                        best.vco_err  = ERR_W'(err);
                    end
                end
            end
        end
        return best;
    endfunction

    // Mirror the configuration registers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stock_limit  <= CFG_W'(STOCK_CLOCK_RST);
            overclock_en <= 1'b0;
        end else if (i_cfg_valid && i_cfg_ready) begin
            if (i_cfg_index == CFG_STOCK_CLOCK) begin
                stock_limit <= i_cfg_data;
            end else begin
                overclock_en <= i_cfg_data[0];
            end
        end
    end

    // Compare each result item with the oldest prediction, then queue new ones
    always @(posedge i_clk) begin : score_items
        t_divider_set due;
        logic         bad;
        if (!i_rst_n) begin
            divider_sets_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (divider_sets_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no item outstanding", results_seen);
                    end
                end else begin
                    due = divider_sets_due.pop_front();
                    bad = (i_found !== due.found) || (i_ref_divider !== due.ref_div) ||
                          (i_feedback_divider !== due.feedback) ||
                          (i_post_divider_one !== due.pd_one) ||
                          (i_post_divider_two !== due.pd_two) ||
                          (i_vco_error_mhz !== due.vco_err);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d target %0d: expected found=%0d ref=%0d fb=%0d",
                                     results_seen, due.target, due.found, due.ref_div,
                                     due.feedback);
                            $display("    pd1=%0d pd2=%0d err=%0d, got found=%0d ref=%0d fb=%0d",
                                     due.pd_one, due.pd_two, due.vco_err, i_found,
                                     i_ref_divider, i_feedback_divider);
                            $display("    pd1=%0d pd2=%0d err=%0d", i_post_divider_one,
                                     i_post_divider_two, i_vco_error_mhz);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                divider_sets_due.push_back(search_dividers(i_target_mhz, stock_limit,
                                                           overclock_en));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= divider_sets_due.size();
    end

endmodule

>>> test/tb_pll_divider_search.sv
module tb_pll_divider_search;
    import pds_pkg::*;

    localparam int QUIET_LIMIT    = 2000;
    localparam int ITEMS_PER_STEP = 125;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [TARGET_W-1:0] target;
    logic                out_valid;
    logic                out_ready;
    logic                found;
    logic                ref_divider;
    logic [FB_OUT_W-1:0] feedback_divider;
    logic [PD_W-1:0]     post_divider_one;
    logic [PD_W-1:0]     post_divider_two;
    logic [ERR_W-1:0]    vco_error_mhz;
    logic                cfg_valid;
    logic                cfg_ready;
    t_cfg_idx            cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    int                  fail_count;
    int                  pending;
    int                  quiet_cycles = 0;
    int                  in_calm = 0;
    int                  out_calm = 0;
    logic [CFG_W-1:0]    cur_stock = CFG_W'(STOCK_CLOCK_RST);

    int dir_stock[10] = '{0, 1, 62, 125, 133, 149, 150, 151, 1024, 2047};
    int dir_oc[10]    = '{151, 200, 800, 1365, 1366, 1600, 1601, 2047, 15, 16};

    pll_divider_search dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_target_mhz       (target),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_found            (found),
        .o_ref_divider      (ref_divider),
        .o_feedback_divider (feedback_divider),
        .o_post_divider_one (post_divider_one),
        .o_post_divider_two (post_divider_two),
        .o_vco_error_mhz    (vco_error_mhz),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    pds_result_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_target_mhz       (target),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_found            (found),
        .i_ref_divider      (ref_divider),
        .i_feedback_divider (feedback_divider),
        .i_post_divider_one (post_divider_one),
        .i_post_divider_two (post_divider_two),
        .i_vco_error_mhz    (vco_error_mhz),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Draw a wait per item, with occasional stretches of back-to-back items
    task automatic draw_wait(inout int calm, output int cycles);
        if (calm > 0) begin
            calm--;
            cycles = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm   = $urandom_range(10, 40);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 17);
        end
    endtask

    // Offer one target and hold it until the block takes it
    task automatic send_target(input logic [TARGET_W-1:0] value);
        int gap;
        draw_wait(in_calm, gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        target   <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending and wait until every predicted result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write both registers back to back
    task automatic set_config(input logic [CFG_W-1:0] limit, input logic oc_en);
        cfg_index <= CFG_STOCK_CLOCK;
        cfg_data  <= limit;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_OVERCLOCK;
        cfg_data  <= CFG_W'(oc_en);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_stock  = limit;
    endtask

    // Mix uniform targets, the dense low range and targets around the stock limit
    function automatic logic [TARGET_W-1:0] pick_target(input logic [CFG_W-1:0] limit);
        int lo;
        int hi;
        lo = (limit > 3) ? int'(limit) - 3 : 0;
        hi = (int'(limit) + 3 > 2047) ? 2047 : int'(limit) + 3;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return TARGET_W'($urandom_range(0, 2047));
            5, 6, 7:       return TARGET_W'($urandom_range(10, 400));
            default:       return TARGET_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Stall the result side at random
    initial begin : drive_out_ready
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            draw_wait(out_calm, stall);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // End the run if no channel moves an item for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int pause_at;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        target    = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STOCK_CLOCK;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default limits, refused targets and empty searches
        foreach (dir_stock[k]) send_target(TARGET_W'(dir_stock[k]));
        drain_results();
        set_config(CFG_W'(STOCK_CLOCK_RST), 1'b1);
        foreach (dir_oc[k]) send_target(TARGET_W'(dir_oc[k]));
        drain_results();
        // Stock limit of zero refuses every nonzero target
        set_config('0, 1'b0);
        send_target('0);
        send_target(TARGET_W'(1));
        drain_results();
        set_config('1, 1'b0);
        send_target('1);
        send_target(TARGET_W'(1600));

        // Random targets over a series of limit settings
        for (int step = 0; step < 8; step++) begin
            drain_results();
            case (step)
                0:       set_config(CFG_W'(STOCK_CLOCK_RST), 1'b0);
                1:       set_config('1, 1'b0);
                2:       set_config('0, 1'b1);
                3:       set_config(CFG_W'($urandom_range(1, 2047)), 1'b0);
                4:       set_config(CFG_W'(1), 1'b0);
                5:       set_config(CFG_W'($urandom_range(1, 2047)), 1'b1);
                6:       set_config('1, 1'b1);
                default: set_config(CFG_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
            endcase
            pause_at = $urandom_range(10, ITEMS_PER_STEP - 10);
            for (int n = 0; n < ITEMS_PER_STEP; n++) begin
                // Let the pipeline run empty once per setting
                if (n == pause_at) begin
                    drain_results();
                end
                send_target(pick_target(cur_stock));
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
